// ----- design/pdsp_pkg.sv -----
package pdsp_pkg;

   // defaults for the top-level parameters
   localparam int COUNT_BITS_DEF = 32;
   localparam int NUM_PINS_DEF   = 2;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int TS_W     = 32;
   localparam int PULSE_W  = 12;
   localparam int CHAN_W   = 3;
   localparam int CSR_IX_W = 2;
   localparam int REQ_USER_W = FUNC_W + 1;
   localparam int RSP_DATA_W = 16;

   // event kinds
   localparam logic [FUNC_W-1:0] FUNC_RISE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FALL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

   // register indexes
   localparam logic [CSR_IX_W-1:0] CSR_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_HIGH_LIMIT = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_OUT_CHAN   = 2'd2;

   // register reset values
   localparam logic [PULSE_W-1:0] LOW_LIMIT_RST  = 12'd950;
   localparam logic [PULSE_W-1:0] HIGH_LIMIT_RST = 12'd1900;
   localparam logic [CHAN_W-1:0]  OUT_CHAN_RST   = 3'd5;

   // duty scaling: q = high_time * 20000 / period, saturated to 12 bits
   localparam int                  DUTY_SCALE_W = 15;
   localparam logic [DUTY_SCALE_W-1:0] DUTY_SCALE = 15'd20000;
   localparam int                  QUO_BITS     = PULSE_W;
   localparam int                  STEP_W       = $clog2(QUO_BITS);
   localparam logic [PULSE_W-1:0]  SAT_MAX      = 12'd4095;
   localparam logic [PULSE_W-1:0]  RELOAD_VALUE = 12'd900;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL,
      ST_CHECK,
      ST_DIVIDE,
      ST_TICK
   } pdsp_state_type;

   typedef struct packed {
      logic load;   // capture the input transaction
      logic rise;   // update period and last rise
      logic diff;   // compute high time
      logic mul;    // scale high time
      logic check;  // saturation test, divider init
      logic step;   // one quotient bit
      logic tick;   // load result register, reload duty
   } pdsp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              pin_ok;
      logic              sat;
      logic              div_last;
      logic              out_free;
   } pdsp_stat_type;

endpackage

// ----- design/pdsp_ctrl.sv -----
module pdsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pdsp_pkg::pdsp_stat_type stat,
   output pdsp_pkg::pdsp_cmd_type  cmd
);
   import pdsp_pkg::*;

   pdsp_state_type state_ff;
   pdsp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (stat.func == FUNC_TICK) begin
               state_in = ST_TICK;
            end else if (stat.func == FUNC_FALL && stat.pin_ok) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL:    state_in = ST_CHECK;
         ST_CHECK:  state_in = stat.sat ? ST_IDLE : ST_DIVIDE;
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DISPATCH: begin
            cmd.rise = (stat.func == FUNC_RISE) && stat.pin_ok;
            cmd.diff = (stat.func == FUNC_FALL) && stat.pin_ok;
         end
         ST_MUL:    cmd.mul   = 1'b1;
         ST_CHECK:  cmd.check = 1'b1;
         ST_DIVIDE: cmd.step  = 1'b1;
         ST_TICK:   cmd.tick  = stat.out_free;
         default: ;
      endcase
   end

endmodule

// ----- design/pdsp_dp.sv -----
module pdsp_dp #(
   parameter int COUNT_BITS = pdsp_pkg::COUNT_BITS_DEF,
   parameter int NUM_PINS   = pdsp_pkg::NUM_PINS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pdsp_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic [pdsp_pkg::TS_W-1:0]         req_tdata,
   input  logic                              csr_valid,
   input  logic [pdsp_pkg::CSR_IX_W-1:0]     csr_index,
   input  logic [pdsp_pkg::PULSE_W-1:0]      csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pdsp_pkg::CHAN_W-1:0]       rsp_chan,
   output logic [pdsp_pkg::PULSE_W-1:0]      rsp_pulse,
   input  pdsp_pkg::pdsp_cmd_type            cmd,
   output pdsp_pkg::pdsp_stat_type           stat
);
   import pdsp_pkg::*;

   localparam int PIN_IX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
   localparam int PROD_W   = COUNT_BITS + DUTY_SCALE_W;
   localparam int HI_W     = PROD_W - QUO_BITS;

   // captured transaction
   logic [FUNC_W-1:0]     func_ff;
   logic                  pin_ff;
   logic [COUNT_BITS-1:0] ts_ff;

   // measurement state
   logic [COUNT_BITS-1:0] last_rise_ff [NUM_PINS];
   logic [COUNT_BITS-1:0] period_ff;
   logic [PULSE_W-1:0]    duty_ff;
   logic [PULSE_W-1:0]    duty_in;

   // divider
   logic [COUNT_BITS-1:0] high_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS-1:0] rem_in;
   logic [QUO_BITS-1:0]   num_lo_ff;
   logic [QUO_BITS-1:0]   quo_ff;
   logic [QUO_BITS-1:0]   quo_in;
   logic [STEP_W-1:0]     step_ff;

   // config
   logic [PULSE_W-1:0]    low_lim_ff;
   logic [PULSE_W-1:0]    high_lim_ff;
   logic [CHAN_W-1:0]     chan_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CHAN_W-1:0]     rsp_chan_ff;
   logic [PULSE_W-1:0]    rsp_pulse_ff;
   logic [PULSE_W-1:0]    clamped;

   logic                  pin_ok;
   logic [PIN_IX_W-1:0]   pin_ix;
   logic [COUNT_BITS-1:0] since_rise;
   logic [HI_W-1:0]       prod_hi;
   logic                  sat;
   logic [COUNT_BITS:0]   trial;
   logic                  ge;

   assign pin_ok     = int'(pin_ff) < NUM_PINS;
   assign pin_ix     = pin_ok ? PIN_IX_W'(pin_ff) : '0;
   assign since_rise = ts_ff - last_rise_ff[pin_ix];

   assign prod_hi = prod_ff[PROD_W-1:QUO_BITS];
   // quotient needs more than 12 bits when prod / 4096 >= period
   assign sat     = (period_ff == '0) || (prod_hi >= HI_W'(period_ff));

   assign trial  = {rem_ff, num_lo_ff[QUO_BITS-1]};
   assign ge     = trial >= {1'b0, period_ff};
   assign rem_in = ge ? COUNT_BITS'(trial - {1'b0, period_ff}) : trial[COUNT_BITS-1:0];
   assign quo_in = {quo_ff[QUO_BITS-2:0], ge};

   always_comb begin
      priority if (duty_ff < low_lim_ff) begin
         clamped = low_lim_ff;
      end else if (duty_ff < high_lim_ff) begin
         clamped = duty_ff;
      end else begin
         clamped = high_lim_ff;
      end
   end

   always_comb begin
      duty_in = duty_ff;
      priority if (cmd.tick) begin
         duty_in = RELOAD_VALUE;
      end else if (cmd.check && sat) begin
         duty_in = SAT_MAX;
      end else if (cmd.step && step_ff == STEP_W'(QUO_BITS - 1)) begin
         duty_in = quo_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PINS; i++) begin
            last_rise_ff[i] <= '0;
         end
         period_ff    <= '0;
         duty_ff      <= '0;
         low_lim_ff   <= LOW_LIMIT_RST;
         high_lim_ff  <= HIGH_LIMIT_RST;
         chan_ff      <= OUT_CHAN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rise) begin
            period_ff            <= since_rise;
            last_rise_ff[pin_ix] <= ts_ff;
         end
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LOW_LIMIT:  low_lim_ff  <= csr_data;
               CSR_HIGH_LIMIT: high_lim_ff <= csr_data;
               CSR_OUT_CHAN:   chan_ff     <= csr_data[CHAN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser[FUNC_W-1:0];
         pin_ff  <= req_tuser[FUNC_W];
         ts_ff   <= req_tdata[COUNT_BITS-1:0];
      end
      if (cmd.diff) begin
         high_ff <= since_rise;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(high_ff) * PROD_W'(DUTY_SCALE);
      end
      if (cmd.check) begin
         rem_ff    <= prod_hi[COUNT_BITS-1:0];
         num_lo_ff <= prod_ff[QUO_BITS-1:0];
         step_ff   <= '0;
      end else if (cmd.step) begin
         rem_ff    <= rem_in;
         num_lo_ff <= {num_lo_ff[QUO_BITS-2:0], 1'b0};
         quo_ff    <= quo_in;
         step_ff   <= step_ff + 1'b1;
      end
      if (cmd.tick) begin
         rsp_chan_ff  <= chan_ff;
         rsp_pulse_ff <= clamped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_chan   = rsp_chan_ff;
   assign rsp_pulse  = rsp_pulse_ff;

   assign stat.func     = func_ff;
   assign stat.pin_ok   = pin_ok;
   assign stat.sat      = sat;
   assign stat.div_last = step_ff == STEP_W'(QUO_BITS - 1);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// ----- design/pwm_duty_to_servo_pulse.sv -----
// PWM duty measurement feeding one servo (PPM) channel.
// Request channel (req_*): one transaction per event. req_tuser carries the
//   event kind (rising edge, falling edge, update tick) and the pin index,
//   req_tdata the free-running timestamp of the edge.
// Response channel (rsp_*): one transaction per tick, carrying the configured
//   channel in rsp_tuser and the clamped pulse width in us in rsp_tdata.
//   Edges never produce a response.
// Config channel (csr_*): always ready; index 0 low limit, 1 high limit,
//   2 output channel. Write only while the block is idle.
// Timing: one event at a time. A rising edge passes IDLE and DISPATCH, a tick
//   also TICK, a falling edge also MUL, CHECK and the restoring divider (one
//   quotient bit per cycle), which is skipped when the quotient saturates.
//   req_tready is high whenever the previous event is finished.
// Stalls: a tick's result sits in an output register; further edges are
//   still taken while it waits, and the next tick waits until it drains.
// Reset: synchronous, clears timestamps, period and stored duty, loads the
//   limits to 950/1900 us and the channel to 5, and empties the output.
module pwm_duty_to_servo_pulse #(
   parameter int COUNT_BITS = pdsp_pkg::COUNT_BITS_DEF,   // 8..32
   parameter int NUM_PINS   = pdsp_pkg::NUM_PINS_DEF      // 1..8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pdsp_pkg::TS_W-1:0]         req_tdata,   // [31:0] timestamp
   input  logic [pdsp_pkg::REQ_USER_W-1:0]   req_tuser,   // [1:0] func, [2] pin_index
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pdsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [11:0] pulse_us, [15:12] zero
   output logic [pdsp_pkg::CHAN_W-1:0]       rsp_tuser,   // [2:0] channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pdsp_pkg::CSR_IX_W-1:0]     csr_index,
   input  logic [pdsp_pkg::PULSE_W-1:0]      csr_data
);
   import pdsp_pkg::*;

   pdsp_cmd_type         cmd;
   pdsp_stat_type        stat;
   logic [PULSE_W-1:0]   pulse;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   pdsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pdsp_dp #(
      .COUNT_BITS (COUNT_BITS),
      .NUM_PINS   (NUM_PINS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_chan   (rsp_tuser),
      .rsp_pulse  (pulse),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_tdata = RSP_DATA_W'(pulse);

endmodule

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pdsp_pkg::*;

   // func code 3 is unused by the block: no state change, no response
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   // cycles a falling edge may still be in the divider after the last response
   localparam int SETTLE_CYCLES = 40;
   // generous cycle budget for the whole run
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [PULSE_W-1:0] pulse;
   } servo_pulse_type;

   // Scoreboard: mirrors the measurement state and keeps the pulses still owed
   class pulse_scoreboard;
      logic [TS_W-1:0]    last_rise [2];
      logic [TS_W-1:0]    period;
      logic [PULSE_W-1:0] duty;
      logic [PULSE_W-1:0] low_lim;
      logic [PULSE_W-1:0] high_lim;
      logic [CHAN_W-1:0]  chan;
      servo_pulse_type    pulses_due [$];
      int                 errors;

      function new();
         last_rise[0] = '0;
         last_rise[1] = '0;
         period   = '0;
         duty     = '0;
         low_lim  = LOW_LIMIT_RST;
         high_lim = HIGH_LIMIT_RST;
         chan     = OUT_CHAN_RST;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_IX_W-1:0] idx, logic [PULSE_W-1:0] data);
         case (idx)
            CSR_LOW_LIMIT:  low_lim  = data;
            CSR_HIGH_LIMIT: high_lim = data;
            CSR_OUT_CHAN:   chan     = data[CHAN_W-1:0];
            default: ;
         endcase
      endfunction

      // high_time * 20000 / period, saturated; zero period saturates too
      function logic [PULSE_W-1:0] scaled_duty(logic [TS_W-1:0] high_time);
         logic [63:0] q;
         if (period == '0)
            return SAT_MAX;
         q = ({32'd0, high_time} * {49'd0, DUTY_SCALE}) / {32'd0, period};
         return (q > {52'd0, SAT_MAX}) ? SAT_MAX : q[PULSE_W-1:0];
      endfunction

      function void note_event(logic [FUNC_W-1:0] func, logic pin, logic [TS_W-1:0] ts);
         servo_pulse_type p;
         case (func)
            FUNC_RISE: begin
               period = ts - last_rise[pin];
               last_rise[pin] = ts;
            end
            FUNC_FALL: duty = scaled_duty(ts - last_rise[pin]);
            FUNC_TICK: begin
               // low test first, so low > high gives high for everything >= low
               p.chan  = chan;
               p.pulse = (duty < low_lim) ? low_lim : (duty < high_lim) ? duty : high_lim;
               pulses_due.push_back(p);
               duty = RELOAD_VALUE;
            end
            default: ;
         endcase
      endfunction

      function void check_pulse(logic [CHAN_W-1:0] chan_got, logic [RSP_DATA_W-1:0] data);
         servo_pulse_type want;
         if (pulses_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, got channel %0d pulse %0d",
                     $time, chan_got, data[PULSE_W-1:0]);
            return;
         end
         want = pulses_due.pop_front();
         if (chan_got !== want.chan) begin
            errors++;
            $display("%0t: channel expected %0d, got %0d", $time, want.chan, chan_got);
         end
         if (data[PULSE_W-1:0] !== want.pulse) begin
            errors++;
            $display("%0t: pulse_us expected %0d, got %0d", $time, want.pulse,
                     data[PULSE_W-1:0]);
         end
         if (data[RSP_DATA_W-1:PULSE_W] !== '0) begin
            errors++;
            $display("%0t: rsp_tdata pad expected 0, got %h", $time,
                     data[RSP_DATA_W-1:PULSE_W]);
         end
      endfunction
   endclass

   // all inputs start at known values
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [TS_W-1:0]         req_tdata  = '0;
   logic [REQ_USER_W-1:0]   req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [CHAN_W-1:0]       rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IX_W-1:0]     csr_index  = '0;
   logic [PULSE_W-1:0]      csr_data   = '0;

   pulse_scoreboard board;
   logic [TS_W-1:0] rise_at [2];   // per-pin time base for well-formed PWM periods
   bit              calm = 1'b0;   // no idling on either side while set
   int              cycles = 0;

   pwm_duty_to_servo_pulse u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] timestamp
      .req_tuser  (req_tuser),    // [1:0] func, [2] pin_index
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [11:0] pulse_us, [15:12] zero
      .rsp_tuser  (rsp_tuser),    // [2:0] channel
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop if the handshakes hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // idles with a chance of about 32 in a hundred, never during the calm stretch
   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < 32);
   endfunction

   // Response side. All drives are NBAs at the edge, so values read right
   // after the edge are the ones the block saw at that edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_pulse(rsp_tuser, rsp_tdata);
         rsp_tready <= !idle_roll();
      end
   end

   // One request transaction. Valid is left high on return so a back-to-back
   // transaction does not lower and raise it in the same step.
   task automatic send_event(input logic [FUNC_W-1:0] func, input logic pin,
                             input logic [TS_W-1:0] ts);
      while (idle_roll()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {pin, func};
      req_tdata  <= ts;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_event(func, pin, ts);
   endtask

   task automatic write_csr(input logic [CSR_IX_W-1:0] idx, input logic [PULSE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic program_limits(input logic [PULSE_W-1:0] low, input logic [PULSE_W-1:0] high,
                                 input logic [CHAN_W-1:0] ch);
      write_csr(CSR_LOW_LIMIT, low);
      write_csr(CSR_HIGH_LIMIT, high);
      write_csr(CSR_OUT_CHAN, {{(PULSE_W-CHAN_W){1'b0}}, ch});
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until every pulse is back, then gives a trailing
   // falling edge time to leave the divider.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pulses_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly rise/fall pairs on one pin with a sane period and duty, plus
   // ticks and some raw noise (any func, any pin, any timestamp).
   task automatic run_random(input int n);
      int              sent;
      int              pick;
      logic            pin;
      logic [TS_W-1:0] span;
      logic [TS_W-1:0] high_time;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_event(FUNC_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
            sent++;
         end else if (pick < 35) begin
            send_event(FUNC_TICK, 1'($urandom_range(1)), $urandom);
            sent++;
         end else begin
            pin  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 5)
               span = $urandom_range(16);           // tiny, zero included
            else if (pick < 10)
               span = $urandom;                     // anywhere in the counter range
            else
               span = $urandom_range(50000, 100);
            pick = $urandom_range(99);
            if (pick < 80)
               high_time = $urandom_range(span / 4); // in range, some saturate
            else if (pick < 90)
               high_time = span;
            else
               high_time = $urandom;
            rise_at[pin] = rise_at[pin] + span;
            send_event(FUNC_RISE, pin, rise_at[pin]);
            send_event(FUNC_FALL, pin, rise_at[pin] + high_time);
            sent += 2;
         end
      end
   endtask

   initial begin
      board = new();
      rise_at[0] = $urandom;
      rise_at[1] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset limits 950/1900, channel 5
      send_event(FUNC_TICK, 1'b0, 32'h0000_0000);     // duty 0 clamps up to low
      send_event(FUNC_FALL, 1'b0, 32'h0000_0064);     // zero period -> saturate
      send_event(FUNC_TICK, 1'b1, 32'hFFFF_FFFF);     // 4095 clamps down to high
      send_event(FUNC_TICK, 1'b0, 32'h0000_0000);     // reloaded 900 -> low
      send_event(FUNC_RISE, 1'b0, 32'hFFFF_FF00);
      send_event(FUNC_RISE, 1'b0, 32'h0000_0F00);     // period wraps to 4096
      send_event(FUNC_FALL, 1'b0, 32'h0000_102C);     // 300 ticks high -> 1464
      send_event(FUNC_TICK, 1'b0, 32'h0000_0000);     // passes through the clamp
      send_event(FUNC_FALL, 1'b0, 32'h0000_1EA0);     // ratio far above 4095
      send_event(FUNC_TICK, 1'b0, 32'h0000_0000);
      send_event(FUNC_NONE, 1'b1, 32'hFFFF_FFFF);     // unused func is ignored
      send_event(FUNC_RISE, 1'b1, 32'hFFFF_FFFF);     // full-range period
      send_event(FUNC_FALL, 1'b1, 32'h0000_0000);     // high time 1 -> 0
      send_event(FUNC_TICK, 1'b1, 32'h0000_0000);
      send_event(FUNC_FALL, 1'b1, 32'hFFFF_FFFE);     // max high time / max period
      send_event(FUNC_RISE, 1'b1, 32'h0000_0000);     // period 1 across the wrap
      send_event(FUNC_FALL, 1'b1, 32'h0000_0000);     // zero high time
      send_event(FUNC_TICK, 1'b1, 32'h0000_0000);
      send_event(FUNC_NONE, 1'b0, 32'h0000_0000);
      send_event(FUNC_TICK, 1'b0, 32'hFFFF_FFFF);
      settle();

      // Widest window, channel 0
      program_limits(12'd0, 12'd4095, 3'd0);
      run_random(330);
      settle();

      // Inverted limits at the extremes; no idling on either side here
      program_limits(12'd4095, 12'd0, 3'd7);
      calm = 1'b1;
      run_random(330);
      calm = 1'b0;
      settle();

      program_limits(12'd1000, 12'd2000, 3'd3);
      run_random(330);
      settle();

      // Inverted, with the reload value below both limits
      program_limits(12'd2500, 12'd1200, 3'd6);
      run_random(330);
      settle();

      program_limits(PULSE_W'($urandom_range(4095)), PULSE_W'($urandom_range(4095)),
                     CHAN_W'($urandom_range(7)));
      run_random(300);
      settle();

      if (board.errors == 0 && board.pulses_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
